@@ hw/rtl/fas_pkg.sv @@
package fas_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;
   localparam int ACC_W       = 32;

   // Register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_START_FRAME  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_FRAME    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_PERIOD = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOOP_FOREVER = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PLAY_COUNT   = 3'd4;

   // Action codes of a request
   localparam logic [1:0] ACT_TICK = 2'd0;
   localparam logic [1:0] ACT_PLAY = 2'd1;
   localparam logic [1:0] ACT_STOP = 2'd2;

   // Result kinds
   localparam logic [1:0] KIND_FRAME   = 2'd0;
   localparam logic [1:0] KIND_STOPPED = 2'd1;
   localparam logic [1:0] KIND_STATUS  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ADD,
      ST_STEP,
      ST_STATUS
   } state_type;

   typedef enum logic {
      ALU_ADD_SAT,
      ALU_SUB_SAT
   } alu_op_type;

   typedef struct packed {
      logic [15:0] start_frame;
      logic [15:0] end_frame;
      logic [23:0] frame_period;
      logic        loop_forever;
      logic [15:0] play_count;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] frame;
      logic [16:0] frame_count;
      logic        playing;
      logic [15:0] times_left;
      logic        last;
   } rsp_data_type;

endpackage

@@ hw/rtl/fas_req_if.sv @@
interface fas_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [23:0] elapsed;
   logic        restart_time;

   modport source (output valid, output action, output elapsed, output restart_time,
                   input ready);
   modport sink   (input valid, input action, input elapsed, input restart_time,
                   output ready);
endinterface

@@ hw/rtl/fas_rsp_if.sv @@
interface fas_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [15:0] frame;
   logic [16:0] frame_count;
   logic        playing;
   logic [15:0] times_left;
   logic        last;

   modport source (output valid, output kind, output frame, output frame_count,
                   output playing, output times_left, output last, input ready);
   modport sink   (input valid, input kind, input frame, input frame_count,
                   input playing, input times_left, input last, output ready);
endinterface

@@ hw/rtl/fas_alu.sv @@
module fas_alu import fas_pkg::*; (
   input  alu_op_type       op,
   input  logic [ACC_W-1:0] a,
   input  logic [ACC_W-1:0] b,
   output logic [ACC_W-1:0] result,
   output logic             a_gt_b
);

   logic [ACC_W:0] b_ext;
   logic [ACC_W:0] sum;
   logic           is_sub;

   assign is_sub = (op == ALU_SUB_SAT);
   assign b_ext  = is_sub ? ~{1'b0, b} : {1'b0, b};
   assign sum    = {1'b0, a} + b_ext + {{ACC_W{1'b0}}, is_sub};

   // In subtract mode the top bit flags a borrow
   assign a_gt_b = is_sub && !sum[ACC_W] && (sum[ACC_W-1:0] != '0);

   always_comb begin
      if (is_sub) begin
         result = a_gt_b ? sum[ACC_W-1:0] : '0;
      end else begin
         result = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
      end
   end

endmodule

@@ hw/rtl/fas_csr.sv @@
module fas_csr import fas_pkg::*; #(
   parameter int FRAME_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   we,
   input  logic [CSR_INDEX_W-1:0] index,
   input  logic [CSR_DATA_W-1:0]  wdata,
   output cfg_type                cfg,
   output logic [16:0]            frame_count
);

   localparam logic [31:0] FMASK32 = (FRAME_BITS >= 32) ? 32'hFFFF_FFFF
                                     : ((32'd1 << FRAME_BITS) - 32'd1);
   localparam logic [15:0] FMASK = FMASK32[15:0];

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   logic [15:0] span;

   always_comb begin
      cfg_in = cfg_ff;
      if (we) begin
         unique case (index)
            CSR_START_FRAME:  cfg_in.start_frame  = wdata[15:0] & FMASK;
            CSR_END_FRAME:    cfg_in.end_frame    = wdata[15:0] & FMASK;
            CSR_FRAME_PERIOD: cfg_in.frame_period = wdata[23:0];
            CSR_LOOP_FOREVER: cfg_in.loop_forever = wdata[0];
            CSR_PLAY_COUNT:   cfg_in.play_count   = wdata[15:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_frame  <= '0;
         cfg_ff.end_frame    <= '0;
         cfg_ff.frame_period <= 24'd1;
         cfg_ff.loop_forever <= 1'b1;
         cfg_ff.play_count   <= 16'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign span = (cfg_ff.end_frame >= cfg_ff.start_frame)
                 ? cfg_ff.end_frame - cfg_ff.start_frame
                 : cfg_ff.start_frame - cfg_ff.end_frame;
   assign frame_count = {1'b0, span} + 17'd1;
   assign cfg = cfg_ff;

endmodule

@@ hw/rtl/fas_seq.sv @@
module fas_seq import fas_pkg::*; #(
   parameter int STEPS_PER_TICK = 16,
   parameter int FRAME_BITS     = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         take,
   input  logic [1:0]   action,
   input  logic [23:0]  elapsed,
   input  logic         restart_time,
   input  cfg_type      cfg,
   input  logic [16:0]  frame_count,
   input  logic         can_emit,
   output logic         ready,
   output logic         emit,
   output rsp_data_type emit_data
);

   localparam int SW = $clog2(STEPS_PER_TICK + 1);

   state_type              state_ff, state_in;
   logic [1:0]             action_ff;
   logic [23:0]            elapsed_ff;
   logic                   restart_ff;
   logic [ACC_W-1:0]       acc_ff, acc_in;
   logic [FRAME_BITS-1:0]  frame_ff, frame_in;
   logic                   running_ff, running_in;
   logic                   fwd_ff, fwd_in;
   logic                   endless_ff, endless_in;
   logic [15:0]            passes_ff, passes_in;
   logic [SW-1:0]          steps_ff, steps_in;

   alu_op_type             alu_op;
   logic [ACC_W-1:0]       alu_b;
   logic [ACC_W-1:0]       alu_res;
   logic                   alu_gt;

   logic [31:0]            start32, end32, frame32;
   logic [FRAME_BITS-1:0]  start_fb, end_fb;
   logic                   step_go;
   logic [1:0]             kind;
   logic                   tl_old;

   assign start32  = {16'b0, cfg.start_frame};
   assign end32    = {16'b0, cfg.end_frame};
   assign start_fb = start32[FRAME_BITS-1:0];
   assign end_fb   = end32[FRAME_BITS-1:0];

   fas_alu u_alu (
      .op     (alu_op),
      .a      (acc_ff),
      .b      (alu_b),
      .result (alu_res),
      .a_gt_b (alu_gt)
   );

   // Shared unit: saturating add of elapsed time, then compare-and-subtract of the period
   always_comb begin
      if (state_ff == ST_STEP) begin
         alu_op = ALU_SUB_SAT;
         alu_b  = {8'b0, cfg.frame_period};
      end else begin
         alu_op = ALU_ADD_SAT;
         alu_b  = {8'b0, elapsed_ff};
      end
   end

   assign step_go = running_ff && alu_gt && (steps_ff < SW'(STEPS_PER_TICK));
   assign ready   = (state_ff == ST_IDLE);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            case (action_ff)
               ACT_TICK: state_in = running_ff ? ST_ADD : ST_STATUS;
               ACT_PLAY: state_in = (!restart_ff || can_emit) ? ST_STATUS : ST_DECODE;
               ACT_STOP: state_in = can_emit ? ST_STATUS : ST_DECODE;
               default:  state_in = ST_STATUS;
            endcase
         end
         ST_ADD:    state_in = ST_STEP;
         ST_STEP: begin
            if (!step_go) state_in = ST_STATUS;
         end
         ST_STATUS: begin
            if (can_emit) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath updates and result generation
   always_comb begin
      acc_in     = acc_ff;
      frame_in   = frame_ff;
      running_in = running_ff;
      fwd_in     = fwd_ff;
      endless_in = endless_ff;
      passes_in  = passes_ff;
      steps_in   = steps_ff;
      emit       = 1'b0;
      kind       = KIND_STATUS;
      tl_old     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_DECODE: begin
            case (action_ff)
               ACT_PLAY: begin
                  if (!restart_ff || can_emit) begin
                     running_in = 1'b1;
                     fwd_in     = (cfg.end_frame >= cfg.start_frame);
                     endless_in = cfg.loop_forever;
                     passes_in  = cfg.play_count;
                     if (restart_ff) begin
                        acc_in   = '0;
                        frame_in = start_fb;
                        emit     = 1'b1;
                        kind     = KIND_FRAME;
                     end
                  end
               end
               ACT_STOP: begin
                  if (can_emit) begin
                     running_in = 1'b0;
                     acc_in     = '0;
                     emit       = 1'b1;
                     kind       = KIND_STOPPED;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_ADD: begin
            acc_in   = alu_res;
            steps_in = '0;
         end
         ST_STEP: begin
            if (step_go && can_emit) begin
               steps_in = steps_ff + SW'(1);
               emit     = 1'b1;
               if (frame_ff != end_fb) begin
                  frame_in = fwd_ff ? frame_ff + FRAME_BITS'(1) : frame_ff - FRAME_BITS'(1);
                  acc_in   = alu_res;
                  kind     = KIND_FRAME;
               end else if (endless_ff || passes_ff > 16'd1) begin
                  // Wrap to the start; the result shows the pass count before the decrement
                  frame_in = start_fb;
                  acc_in   = alu_res;
                  kind     = KIND_FRAME;
                  tl_old   = 1'b1;
                  if (!endless_ff) passes_in = passes_ff - 16'd1;
               end else begin
                  running_in = 1'b0;
                  acc_in     = '0;
                  kind       = KIND_STOPPED;
               end
            end
         end
         ST_STATUS: begin
            emit = can_emit;
            kind = KIND_STATUS;
         end
         default: begin
         end
      endcase
   end

   assign frame32 = 32'(frame_in);

   always_comb begin
      emit_data.kind        = kind;
      emit_data.frame       = frame32[15:0];
      emit_data.frame_count = frame_count;
      emit_data.playing     = running_in;
      if (endless_in) begin
         emit_data.times_left = 16'd1;
      end else if (tl_old) begin
         emit_data.times_left = passes_ff;
      end else begin
         emit_data.times_left = passes_in;
      end
      emit_data.last        = (kind == KIND_STATUS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         acc_ff     <= '0;
         frame_ff   <= '0;
         running_ff <= 1'b0;
         fwd_ff     <= 1'b1;
         endless_ff <= 1'b1;
         passes_ff  <= 16'd1;
         steps_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         acc_ff     <= acc_in;
         frame_ff   <= frame_in;
         running_ff <= running_in;
         fwd_ff     <= fwd_in;
         endless_ff <= endless_in;
         passes_ff  <= passes_in;
         steps_ff   <= steps_in;
      end
   end

   // Hold the request payload for the life of the item
   always_ff @(posedge clock) begin
      if (take) begin
         action_ff  <= action;
         elapsed_ff <= elapsed;
         restart_ff <= restart_time;
      end
   end

endmodule

@@ hw/rtl/frame_animation_sequencer.sv @@
// Sprite animation frame stepper.
// req channel: one transfer per item carrying action (tick, play, stop),
// elapsed time units (tick only) and restart_time (play only).
// rsp channel: each item yields zero or more events (frame changed, stopped)
// followed by exactly one status transfer with last set.
// csr port: write-only registers start_frame, end_frame, frame_period,
// loop_forever and play_count; write them only while the block is idle.
// Flow: a play, a stop or a tick while stopped goes from decode to its
// status (held while the receiver stalls). A running tick first does the
// saturating add of the elapsed time, then advances frames in the step state,
// at most STEPS_PER_TICK of them: all on the single shared 33-bit adder that
// adds the elapsed time and compares and subtracts the frame period.
// req.ready is high only between items; a new item is taken while the status
// of the previous one still waits in the output register.
// Reset clears the time, frame 0, not playing, forward, endless, one pass,
// and loads the register defaults. A stalled receiver freezes the sequencer
// until the held result is taken; nothing is dropped.
module frame_animation_sequencer import fas_pkg::*; #(
   parameter int STEPS_PER_TICK = 16,
   parameter int FRAME_BITS     = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   fas_req_if.sink                req,
   fas_rsp_if.source              rsp
);

   cfg_type      cfg;
   logic [16:0]  frame_count;
   logic         seq_ready;
   logic         emit;
   rsp_data_type emit_data;
   logic         take;
   logic         can_emit;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff;

   fas_csr #(
      .FRAME_BITS (FRAME_BITS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .we          (csr_we),
      .index       (csr_index),
      .wdata       (csr_wdata),
      .cfg         (cfg),
      .frame_count (frame_count)
   );

   // Accept a request only between items
   assign req.ready = seq_ready;
   assign take      = req.valid && seq_ready;

   // The output slot is free when empty or being drained this cycle
   assign can_emit = !rsp_valid_ff || rsp.ready;

   fas_seq #(
      .STEPS_PER_TICK (STEPS_PER_TICK),
      .FRAME_BITS     (FRAME_BITS)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .action       (req.action),
      .elapsed      (req.elapsed),
      .restart_time (req.restart_time),
      .cfg          (cfg),
      .frame_count  (frame_count),
      .can_emit     (can_emit),
      .ready        (seq_ready),
      .emit         (emit),
      .emit_data    (emit_data)
   );

   // Output register: load on emit, drop valid once the transfer completes
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= emit_data;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.kind        = rsp_data_ff.kind;
   assign rsp.frame       = rsp_data_ff.frame;
   assign rsp.frame_count = rsp_data_ff.frame_count;
   assign rsp.playing     = rsp_data_ff.playing;
   assign rsp.times_left  = rsp_data_ff.times_left;
   assign rsp.last        = rsp_data_ff.last;

endmodule
